// File: rtl/rgbhsv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types and register codes for the RGB to HSV/HSL converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int unsigned ChBits  = 16;
  localparam int unsigned CfgBits = 16;
  localparam int unsigned MinChromaBits = 16;

  typedef enum logic [1:0] {
    MODE_RAW = 2'd0,
    MODE_HSV = 2'd1,
    MODE_HSL = 2'd2,
    MODE_RSV = 2'd3
  } color_mode_e;

  typedef enum logic {
    REG_COLOR_MODE = 1'b0,
    REG_MIN_CHROMA = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [ChBits-1:0] red;
    logic [ChBits-1:0] green;
    logic [ChBits-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [ChBits-1:0] hue_or_red;
    logic [ChBits-1:0] sat_or_green;
    logic [ChBits-1:0] level_or_blue;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/rgbhsv_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_div
// Pipelined restoring divider, one quotient bit per stage:
// quo = floor(num * 2^QB / den), saturated, with a side payload carried along.
// ----------------------------------------------------------------------------
module rgbhsv_div #(
  parameter int unsigned NB = 19,
  parameter int unsigned QB = 16,
  parameter int unsigned PB = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          vld_i,
  input  wire logic [NB-1:0] num_i,
  input  wire logic [NB-1:0] den_i,
  input  wire logic [PB-1:0] pay_i,
  output logic               vld_o,
  output logic [QB-1:0]      quo_o,
  output logic [PB-1:0]      pay_o
);

  logic [QB:0]        vld_q;
  logic [NB:0]        rem_q [QB+1];
  logic [NB-1:0]      den_q [QB+1];
  logic [QB-1:0]      quo_q [QB+1];
  logic [QB:0]        sat_q;
  logic [PB-1:0]      pay_q [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QB-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= {1'b0, num_i};
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    sat_q[0] <= (den_i == '0) || (num_i >= den_i);
    pay_q[0] <= pay_i;
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [NB+1:0] sh;
    logic          ge;
    assign sh = {rem_q[s], 1'b0};
    assign ge = sh >= {2'b00, den_q[s]};
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= ge ? (NB+1)'(sh - {2'b00, den_q[s]}) : sh[NB:0];
      den_q[s+1] <= den_q[s];
      quo_q[s+1] <= {quo_q[s][QB-2:0], ge};
      sat_q[s+1] <= sat_q[s];
      pay_q[s+1] <= pay_q[s];
    end
  end

  assign vld_o = vld_q[QB];
  assign quo_o = sat_q[QB] ? '1 : quo_q[QB];
  assign pay_o = pay_q[QB];

endmodule
`default_nettype wire

// File: rtl/rgb_to_hsv_hsl_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_hsl_converter
// RGB pixel to HSV or HSL triple, or raw passthrough, fully pipelined.
// ----------------------------------------------------------------------------
// Every mode takes the same path through the pipeline from start to done_o.
// Throughput: one pixel per cycle; busy is tied low and done_o cannot be held off.
// Depth is set by the two bit-serial divider pipelines in series, one bit per stage.
// Reset clears the valid pipeline and loads color_mode 0, min_chroma 7.
module rgb_to_hsv_hsl_converter #(
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [CHANNEL_BITS-1:0] red_i,
  input  wire logic [CHANNEL_BITS-1:0] green_i,
  input  wire logic [CHANNEL_BITS-1:0] blue_i,
  output logic                         done_o,
  output logic [CHANNEL_BITS-1:0]      hue_or_red_o,
  output logic [CHANNEL_BITS-1:0]      sat_or_green_o,
  output logic [CHANNEL_BITS-1:0]      level_or_blue_o,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_idx_i,
  input  wire logic [rgbhsv_pkg::CfgBits-1:0] cfg_data_i
);

  localparam int unsigned B  = CHANNEL_BITS;
  localparam int unsigned NB = B + 3;
  localparam int unsigned PB = 3 * B + 2;
  localparam logic [B:0]  One = {1'b1, {B{1'b0}}};

  rgbhsv_pkg::color_mode_e mode_q;
  logic [rgbhsv_pkg::MinChromaBits-1:0] minc_q;
  logic [B-1:0] thr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rgbhsv_pkg::MODE_RAW;
      minc_q <= 16'd7;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rgbhsv_pkg::REG_COLOR_MODE: mode_q <= rgbhsv_pkg::color_mode_e'(cfg_data_i[1:0]);
        rgbhsv_pkg::REG_MIN_CHROMA: minc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  if (B >= 16) begin : g_thr_up
    assign thr = B'(minc_q) << (B - 16);
  end else begin : g_thr_dn
    assign thr = minc_q[15 -: B];
  end

  assign busy = 1'b0;

  // stage 1: max, min, max channel
  logic         v1_q;
  logic [B-1:0] r1_q, g1_q, b1_q, mx1_q, mn1_q;
  logic [1:0]   sx1_q;
  logic         hsv1_q, hsl1_q;
  logic [B-1:0] mx1_d, mn1_d;
  logic [1:0]   sx1_d;

  always_comb begin
    mx1_d = (red_i > green_i) ? red_i : green_i;
    if (blue_i > mx1_d) mx1_d = blue_i;
    mn1_d = (red_i < green_i) ? red_i : green_i;
    if (blue_i < mn1_d) mn1_d = blue_i;
    if (mx1_d == red_i)        sx1_d = 2'd0;
    else if (mx1_d == green_i) sx1_d = 2'd1;
    else                       sx1_d = 2'd2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    r1_q <= red_i; g1_q <= green_i; b1_q <= blue_i;
    mx1_q <= mx1_d; mn1_q <= mn1_d; sx1_q <= sx1_d;
    hsv1_q <= mode_q == rgbhsv_pkg::MODE_HSV;
    hsl1_q <= mode_q == rgbhsv_pkg::MODE_HSL;
  end

  // stage 2: chroma, sums, hue numerator, saturation operands
  logic          v2_q;
  logic [NB-1:0] sn2_q, sd2_q, hn2_q, hd2_q;
  logic          sok2_q, hok2_q;
  logic [PB-1:0] pay2_q;
  logic [B-1:0]  c_d;
  logic [B:0]    s_d;
  logic [NB-1:0] hn_d, c6_d;
  logic [NB:0]   hs_d;

  always_comb begin
    c_d  = mx1_q - mn1_q;
    s_d  = {1'b0, mx1_q} + {1'b0, mn1_q};
    c6_d = NB'({c_d, 2'b00}) + NB'({c_d, 1'b0});
    unique case (sx1_q)
      2'd0:    hs_d = (NB+1)'(g1_q) - (NB+1)'(b1_q);
      2'd1:    hs_d = (NB+1)'({c_d, 1'b0}) + (NB+1)'(b1_q) - (NB+1)'(r1_q);
      default: hs_d = (NB+1)'({c_d, 2'b00}) + (NB+1)'(r1_q) - (NB+1)'(g1_q);
    endcase
    hn_d = hs_d[NB] ? NB'(hs_d + (NB+1)'(c6_d)) : hs_d[NB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    hn2_q <= hn_d;
    hd2_q <= c6_d;
    sn2_q <= NB'(c_d);
    if (hsv1_q) begin
      sd2_q  <= NB'(mx1_q);
      sok2_q <= (mx1_q >= thr) && (mx1_q != '0);
      hok2_q <= 1'b1;
    end else begin
      sd2_q  <= (s_d <= One) ? NB'(s_d) : NB'({One, 1'b0} - (B+2)'(s_d));
      sok2_q <= (c_d >= thr) && (c_d != '0);
      hok2_q <= (c_d >= thr) && (c_d != '0);
    end
    pay2_q <= {hsv1_q, hsl1_q, r1_q, g1_q,
               hsv1_q ? mx1_q : (hsl1_q ? s_d[B:1] : b1_q)};
  end

  // stage 3: saturation divider, then hue divider
  logic          vs_w, vh_w, v4_q;
  logic [B-1:0]  sq_w, hq_w;
  logic [PB-1:0] ps_w, ph_w;
  logic [NB-1:0] hn4_q, hd4_q;
  logic [B-1:0]  sat4_q;
  logic          hok4_q;
  logic [PB-1:0] pay4_q;
  logic [2*NB:0] side_w;
  logic [B-1:0]  sq_fin_w;
  logic          hok_fin_w;

  rgbhsv_div #(.NB(NB), .QB(B), .PB(PB + 2*NB + 1)) u_sdiv (
    .clk_i, .rst_ni,
    .vld_i(v2_q), .num_i(sn2_q), .den_i(sd2_q),
    .pay_i({pay2_q, hn2_q, hd2_q, hok2_q && sok2_q}),
    .vld_o(vs_w), .quo_o(sq_w), .pay_o({ps_w, side_w})
  );

  logic [B-1:0] sat_d;
  logic         hok_d;
  always_comb begin
    sat_d = side_w[0] || (ps_w[PB-1] && (sq_w != '0 || 1'b1)) ? sq_w : '0;
    if (!side_w[0] && !ps_w[PB-1]) sat_d = '0;
    if (ps_w[PB-1]) begin
      // HSV: side bit only says sat valid; recompute from payload gating
      sat_d = side_w[0] ? sq_w : '0;
      hok_d = side_w[0] && (sq_w >= thr);
    end else begin
      hok_d = side_w[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= vs_w;
  end

  always_ff @(posedge clk_i) begin
    hn4_q  <= side_w[2*NB:NB+1];
    hd4_q  <= side_w[NB:1];
    sat4_q <= sat_d;
    hok4_q <= hok_d && (side_w[NB:1] != '0);
    pay4_q <= ps_w;
  end

  rgbhsv_div #(.NB(NB), .QB(B), .PB(PB + B + 1)) u_hdiv (
    .clk_i, .rst_ni,
    .vld_i(v4_q), .num_i(hn4_q), .den_i(hd4_q),
    .pay_i({pay4_q, sat4_q, hok4_q}),
    .vld_o(vh_w), .quo_o(hq_w), .pay_o({ph_w, sq_fin_w, hok_fin_w})
  );

  // output register
  logic         done_q;
  logic [B-1:0] h_q, s_q, l_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= vh_w;
  end

  always_ff @(posedge clk_i) begin
    if (ph_w[PB-1] || ph_w[PB-2]) begin
      h_q <= hok_fin_w ? hq_w : '0;
      s_q <= sq_fin_w;
    end else begin
      h_q <= ph_w[3*B-1:2*B];
      s_q <= ph_w[2*B-1:B];
    end
    l_q <= ph_w[B-1:0];
  end

  assign done_o = done_q;
  assign hue_or_red_o = h_q;
  assign sat_or_green_o = s_q;
  assign level_or_blue_o = l_q;

`ifndef SYNTHESIS
  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy asserted");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q)) else $error("valid chain broken");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vh_w)) else $error("spurious done");
`endif

endmodule
`default_nettype wire

// File: bench/rgb_hsv_checker.sv
// ----------------------------------------------------------------------------
// rgb_hsv_checker
// Watches the pixel, config and result channels of the RGB to HSV/HSL
// converter. Predicts every triple from the accepted pixel and the current
// mode and threshold, queues it, and compares each done_o beat field by field.
// ----------------------------------------------------------------------------
module rgb_hsv_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  input  logic                           busy,
  input  rgbhsv_pkg::pixel_t             pixel_i,
  input  logic                           done_o,
  input  rgbhsv_pkg::result_t            result_i,
  input  logic                           cfg_we_i,
  input  rgbhsv_pkg::reg_idx_e           cfg_idx_i,
  input  logic [rgbhsv_pkg::CfgBits-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  rgbhsv_pkg::color_mode_e mode_q;
  logic [15:0]             thr_q;
  rgbhsv_pkg::result_t     triple_q[$];
  int                      fails;

  assign fail_count_o = fails;
  assign pending_o    = triple_q.size();

  function automatic logic [15:0] fixed_quotient(logic [18:0] num, logic [18:0] den);
    logic [19:0] rem;
    logic [15:0] q;
    if (den == 0 || num >= den) return 16'hffff;
    rem = {1'b0, num};
    q = '0;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [15:0] hue_turns(rgbhsv_pkg::pixel_t p, int mx, int c);
    int num;
    if (mx == p.red) num = int'(p.green) - int'(p.blue);
    else if (mx == p.green) num = 2 * c + int'(p.blue) - int'(p.red);
    else num = 4 * c + int'(p.red) - int'(p.green);
    if (num < 0) num += 6 * c;
    return fixed_quotient(num[18:0], 19'(6 * c));
  endfunction

  function automatic rgbhsv_pkg::result_t convert_pixel(rgbhsv_pkg::pixel_t p,
                                                         rgbhsv_pkg::color_mode_e m,
                                                         logic [15:0] thr);
    rgbhsv_pkg::result_t r;
    int mx, mn, c, s;
    logic [15:0] sat, hue;
    if (m != rgbhsv_pkg::MODE_HSV && m != rgbhsv_pkg::MODE_HSL)
      return rgbhsv_pkg::result_t'(p);
    mx = p.red > p.green ? p.red : p.green;
    if (p.blue > mx) mx = p.blue;
    mn = p.red < p.green ? p.red : p.green;
    if (p.blue < mn) mn = p.blue;
    c = mx - mn;
    s = mx + mn;
    sat = '0;
    hue = '0;
    if (m == rgbhsv_pkg::MODE_HSV) begin
      if (mx >= thr && mx != 0) sat = fixed_quotient(c[18:0], mx[18:0]);
      if (sat >= thr && c != 0) hue = hue_turns(p, mx, c);
      r.level_or_blue = mx[15:0];
    end else begin
      if (c >= thr && c != 0) begin
        if (s <= 65536) sat = fixed_quotient(c[18:0], s[18:0]);
        else sat = fixed_quotient(c[18:0], 19'(131072 - s));
        hue = hue_turns(p, mx, c);
      end
      r.level_or_blue = s[16:1];
    end
    r.hue_or_red = hue;
    r.sat_or_green = sat;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rgbhsv_pkg::result_t want;
    if (!rst_ni) begin
      mode_q <= rgbhsv_pkg::MODE_RAW;
      thr_q <= 16'd7;
      triple_q.delete();
      fails <= 0;
    end else begin
      if (start && !busy) triple_q.push_back(convert_pixel(pixel_i, mode_q, thr_q));
      if (done_o) begin
        if (triple_q.size() == 0) begin
          if (fails < 10) $display("unexpected result beat %h", result_i);
          fails <= fails + 1;
        end else begin
          want = triple_q.pop_front();
          if (want !== result_i) begin
            if (fails < 10)
              $display("mismatch hue/r exp %h got %h, sat/g exp %h got %h, lvl/b exp %h got %h",
                       want.hue_or_red, result_i.hue_or_red, want.sat_or_green,
                       result_i.sat_or_green, want.level_or_blue, result_i.level_or_blue);
            fails <= fails + 1;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == rgbhsv_pkg::REG_COLOR_MODE)
          mode_q <= rgbhsv_pkg::color_mode_e'(cfg_data_i[1:0]);
        else thr_q <= cfg_data_i[15:0];
      end
    end
  end

endmodule

// File: bench/tb_rgb_to_hsv_hsl_converter.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_hsl_converter
// Drives directed (HSV, HSL) and random pixels through every mode over a range
// of thresholds, with random start gaps; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_hsl_converter;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  rgbhsv_pkg::pixel_t             pixel_d = '0;
  logic                           done_o;
  rgbhsv_pkg::result_t            result_q;
  logic                           cfg_we_i = 1'b0;
  rgbhsv_pkg::reg_idx_e           cfg_idx_i = rgbhsv_pkg::REG_COLOR_MODE;
  logic [rgbhsv_pkg::CfgBits-1:0] cfg_data_i = '0;
  int                             fail_count;
  int                             pending;
  int                             gap_pct;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rgb_to_hsv_hsl_converter dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .red_i(pixel_d.red), .green_i(pixel_d.green), .blue_i(pixel_d.blue),
    .done_o(done_o), .hue_or_red_o(result_q.hue_or_red),
    .sat_or_green_o(result_q.sat_or_green), .level_or_blue_o(result_q.level_or_blue),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  rgb_hsv_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .pixel_i(pixel_d),
    .done_o(done_o), .result_i(result_q), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .fail_count_o(fail_count), .pending_o(pending)
  );

  task automatic send_pixel(rgbhsv_pkg::pixel_t p);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    pixel_d <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(rgbhsv_pkg::reg_idx_e idx, logic [rgbhsv_pkg::CfgBits-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  function automatic rgbhsv_pkg::pixel_t random_pixel();
    rgbhsv_pkg::pixel_t p;
    logic [15:0] base;
    p = rgbhsv_pkg::pixel_t'(48'({$urandom, $urandom}));
    case ($urandom_range(5))
      0: begin
        base = 16'($urandom);
        p.red = base + 16'($urandom_range(3));
        p.green = base + 16'($urandom_range(3));
        p.blue = base + 16'($urandom_range(3));
      end
      1: p.green = p.red;
      2: p.blue = ($urandom_range(1) != 0) ? p.red : p.green;
      3: begin
        p.red = p.red >> $urandom_range(15);
        p.green = p.green >> $urandom_range(15);
        p.blue = p.blue >> $urandom_range(15);
      end
      default: ;
    endcase
    return p;
  endfunction

  rgbhsv_pkg::pixel_t directed[20] = '{
    '{16'h0000, 16'h0000, 16'h0000}, '{16'hffff, 16'hffff, 16'hffff},
    '{16'hffff, 16'h0000, 16'h0000}, '{16'h0000, 16'hffff, 16'h0000},
    '{16'h0000, 16'h0000, 16'hffff}, '{16'hffff, 16'hffff, 16'h0000},
    '{16'h0000, 16'hffff, 16'hffff}, '{16'hffff, 16'h0000, 16'hffff},
    '{16'h8000, 16'h8000, 16'h8000}, '{16'h0006, 16'h0000, 16'h0000},
    '{16'h0007, 16'h0000, 16'h0000}, '{16'h8003, 16'h8000, 16'h8000},
    '{16'h8007, 16'h8000, 16'h8000}, '{16'h8000, 16'h0000, 16'h8000},
    '{16'hffff, 16'h0001, 16'h0000}, '{16'hffff, 16'h0000, 16'h0001},
    '{16'h8000, 16'h0000, 16'h0000}, '{16'h8001, 16'h0000, 16'h0000},
    '{16'hc000, 16'h4000, 16'h4001}, '{16'h1234, 16'hfedc, 16'h5a5a}
  };

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rgbhsv_pkg::color_mode_e modes[12] = '{
      rgbhsv_pkg::MODE_HSV, rgbhsv_pkg::MODE_HSL, rgbhsv_pkg::MODE_RAW,
      rgbhsv_pkg::MODE_HSV, rgbhsv_pkg::MODE_HSL, rgbhsv_pkg::MODE_HSV,
      rgbhsv_pkg::MODE_HSL, rgbhsv_pkg::MODE_RSV, rgbhsv_pkg::MODE_HSV,
      rgbhsv_pkg::MODE_HSL, rgbhsv_pkg::MODE_HSV, rgbhsv_pkg::MODE_HSL};
    logic [15:0] thrs[12] = '{16'd7, 16'd7, 16'd7, 16'd0, 16'd0, 16'hffff,
                              16'hffff, 16'd7, 16'h8000, 16'h0100, 16'd1, 16'd7};
    gap_pct = 25;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (modes[i]) begin
      if (i == 11) thrs[i] = 16'($urandom);
      write_reg(rgbhsv_pkg::REG_COLOR_MODE, rgbhsv_pkg::CfgBits'(modes[i]));
      write_reg(rgbhsv_pkg::REG_MIN_CHROMA, thrs[i]);
      gap_pct = (i == 4) ? 0 : 25;
      if (i < 2) foreach (directed[j]) send_pixel(directed[j]);
      repeat (137) send_pixel(random_pixel());
      drain_pipe();
    end
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
